FILE: sv/qpp_pkg.sv
// ----------------------------------------------------------------------------
// qpp_pkg
// Shared widths, codes and types of the quaternion point projector.
// ----------------------------------------------------------------------------
package qpp_pkg;

  // Field widths
  localparam int COORD_W   = 16;
  localparam int KIND_W    = 2;
  // One q part times one coordinate
  localparam int PROD_W    = 2 * COORD_W;
  // Sum of three such products, with headroom
  localparam int TERM_W    = PROD_W + 2;
  // One term times one q part
  localparam int MUL_W     = TERM_W + COORD_W;
  // Sum of four such products, with headroom
  localparam int ROT_W     = MUL_W + 2;
  // Q1.14 squared gives a scale of 2^28
  localparam int ROT_SHIFT = 28;
  localparam int QUO_W     = ROT_W - ROT_SHIFT;
  // Quotient plus offset plus bias
  localparam int SUM_W     = QUO_W + 2;

  // Point kinds
  localparam logic [KIND_W-1:0] KIND_DRAW = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SKIP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // Special values
  localparam logic signed [COORD_W-1:0] END_MARK   = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] PIXEL_BIAS = 16'sd15;
  localparam logic signed [COORD_W-1:0] QUAT_ONE   = 16'sd16384;

  // Register map
  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = REG_IDX_W + 2;
  localparam int APB_DATA_W = 32;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_W   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_X   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_Y   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_QUAT_Z   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd5;

  // Configuration seen by the datapath
  typedef struct packed {
    logic signed [COORD_W-1:0] quat_w;
    logic signed [COORD_W-1:0] quat_x;
    logic signed [COORD_W-1:0] quat_y;
    logic signed [COORD_W-1:0] quat_z;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
  } cfg_t;

endpackage

FILE: sv/qpp_ifs.sv
// ----------------------------------------------------------------------------
// qpp_ifs
// Valid/ready channels: model points in, projected pixels out.
// ----------------------------------------------------------------------------
interface qpp_point_if import qpp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

interface qpp_pixel_if import qpp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [KIND_W-1:0]  point_kind;
  logic signed [COORD_W-1:0] pixel_x;
  logic signed [COORD_W-1:0] pixel_y;

  modport source (output valid, output point_kind, output pixel_x, output pixel_y,
                  input ready);
  modport sink   (input valid, input point_kind, input pixel_x, input pixel_y,
                  output ready);
endinterface

FILE: sv/qpp_pipe.sv
// ----------------------------------------------------------------------------
// qpp_pipe
// Six-stage rotate/project pipeline: classify and q*v products, t sums, t*q products,
// r sums, truncating shift, offset add with saturation into the output word (zero if undrawn).
// ----------------------------------------------------------------------------
module qpp_pipe import qpp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  qpp_point_if.sink   points,
  qpp_pixel_if.source pixels
);

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

  // Stage valids and kinds
  logic [5:0]        vld;
  logic [KIND_W-1:0] kind1, kind2, kind3, kind4, kind5, kind6;

  // Whole pipe moves when the output word is free or being taken
  logic adv;
  assign adv          = !vld[5] || pixels.ready;
  assign points.ready = adv;

  // ---------------- stage 1: classify, q part x coordinate -----------------
  logic              is_end, is_neg;
  logic [KIND_W-1:0] kind_in;
  logic signed [PROD_W-1:0] prod [4][3];
  logic signed [COORD_W-1:0] qv [4];
  logic signed [COORD_W-1:0] pv [3];

  assign is_end = (points.point_x == END_MARK) && (points.point_y == END_MARK) &&
                  (points.point_z == END_MARK);
  assign is_neg = points.point_x[COORD_W-1] | points.point_y[COORD_W-1] |
                  points.point_z[COORD_W-1];

  always_comb begin
    if (is_end) begin
      kind_in = KIND_END;
    end else if (is_neg) begin
      kind_in = KIND_SKIP;
    end else begin
      kind_in = KIND_DRAW;
    end
  end

  // index 0..3 = w,x,y,z ; 0..2 = x,y,z
  assign qv[0] = cfg.quat_w;
  assign qv[1] = cfg.quat_x;
  assign qv[2] = cfg.quat_y;
  assign qv[3] = cfg.quat_z;
  assign pv[0] = points.point_x;
  assign pv[1] = points.point_y;
  assign pv[2] = points.point_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      kind1 <= kind_in;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PROD_W'(qv[i] * pv[j]);
        end
      end
    end
  end

  // ---------------- stage 2: t = q * (0,v) ---------------------------------
  logic signed [TERM_W-1:0] tw, tx, ty, tz;

  always_ff @(posedge clk) begin
    if (adv) begin
      kind2 <= kind1;
      tw <= -TERM_W'(prod[1][0]) - TERM_W'(prod[2][1]) - TERM_W'(prod[3][2]);
      tx <=  TERM_W'(prod[0][0]) + TERM_W'(prod[2][2]) - TERM_W'(prod[3][1]);
      ty <=  TERM_W'(prod[0][1]) - TERM_W'(prod[1][2]) + TERM_W'(prod[3][0]);
      tz <=  TERM_W'(prod[0][2]) + TERM_W'(prod[1][1]) - TERM_W'(prod[2][0]);
    end
  end

  // ---------------- stage 3: t x q part products ----------------------------
  logic signed [MUL_W-1:0] mx [4];
  logic signed [MUL_W-1:0] mz [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      kind3 <= kind2;
      mx[0] <= MUL_W'(tw * cfg.quat_x);
      mx[1] <= MUL_W'(tx * cfg.quat_w);
      mx[2] <= MUL_W'(ty * cfg.quat_z);
      mx[3] <= MUL_W'(tz * cfg.quat_y);
      mz[0] <= MUL_W'(tw * cfg.quat_z);
      mz[1] <= MUL_W'(tx * cfg.quat_y);
      mz[2] <= MUL_W'(ty * cfg.quat_x);
      mz[3] <= MUL_W'(tz * cfg.quat_w);
    end
  end

  // ---------------- stage 4: r = t * conj(q) --------------------------------
  logic signed [ROT_W-1:0] rx, rz;

  always_ff @(posedge clk) begin
    if (adv) begin
      kind4 <= kind3;
      rx <= -ROT_W'(mx[0]) + ROT_W'(mx[1]) - ROT_W'(mx[2]) + ROT_W'(mx[3]);
      rz <= -ROT_W'(mz[0]) - ROT_W'(mz[1]) + ROT_W'(mz[2]) + ROT_W'(mz[3]);
    end
  end

  // ---------------- stage 5: divide by 2^28, toward zero ---------------------
  logic signed [QUO_W-1:0] quo_x, quo_z;
  logic        [QUO_W-1:0] rnd_x, rnd_z;

  // negative with a nonzero remainder rounds up by one
  assign rnd_x = QUO_W'(rx[ROT_W-1] & (|rx[ROT_SHIFT-1:0]));
  assign rnd_z = QUO_W'(rz[ROT_W-1] & (|rz[ROT_SHIFT-1:0]));

  always_ff @(posedge clk) begin
    if (adv) begin
      kind5 <= kind4;
      quo_x <= rx[ROT_W-1:ROT_SHIFT] + rnd_x;
      quo_z <= rz[ROT_W-1:ROT_SHIFT] + rnd_z;
    end
  end

  // ---------------- stage 6: offset, saturate, output word ------------------
  logic signed [SUM_W-1:0]   sum_x, sum_y;
  logic signed [COORD_W-1:0] sat_x, sat_y;
  logic signed [COORD_W-1:0] pix_x, pix_y;

  assign sum_x = SUM_W'(quo_z) + SUM_W'(cfg.origin_x) + SUM_W'(PIXEL_BIAS);
  assign sum_y = SUM_W'(quo_x) + SUM_W'(cfg.origin_y) + SUM_W'(PIXEL_BIAS);

  always_comb begin
    if (sum_x > SAT_HI) begin
      sat_x = SAT_HI[COORD_W-1:0];
    end else if (sum_x < SAT_LO) begin
      sat_x = SAT_LO[COORD_W-1:0];
    end else begin
      sat_x = sum_x[COORD_W-1:0];
    end
    if (sum_y > SAT_HI) begin
      sat_y = SAT_HI[COORD_W-1:0];
    end else if (sum_y < SAT_LO) begin
      sat_y = SAT_LO[COORD_W-1:0];
    end else begin
      sat_y = sum_y[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind6 <= kind5;
      if (kind5 == KIND_DRAW) begin
        pix_x <= sat_x;
        pix_y <= sat_y;
      end else begin
        pix_x <= '0;
        pix_y <= '0;
      end
    end
  end

  // ---------------- valid bits ---------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[4:0], points.valid};
    end
  end

  assign pixels.valid      = vld[5];
  assign pixels.point_kind = kind6;
  assign pixels.pixel_x    = pix_x;
  assign pixels.pixel_y    = pix_y;

  // ---------------- assertions ---------------------------------------------
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valids moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    points.valid && points.ready |=> vld[0])
    else $error("accepted word did not enter stage 1");

  a_undrawn_zero: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && (pixels.point_kind != KIND_DRAW) |->
      (pixels.pixel_x == '0) && (pixels.pixel_y == '0))
    else $error("undrawn point carries nonzero pixel");

  a_out_no_drop: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && !pixels.ready |=> pixels.valid)
    else $error("output word dropped while stalled");

endmodule

FILE: sv/quaternion_point_projector.sv
// ----------------------------------------------------------------------------
// quaternion_point_projector
// Rotates model points by a configured quaternion and projects them to pixels.
// Throughput: one point per cycle; a stall at the output holds all six stages.
// Reset clears all stage valids and loads the identity quaternion, zero origin.
// ----------------------------------------------------------------------------
module quaternion_point_projector import qpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  qpp_point_if.sink             points,
  qpp_pixel_if.source           pixels
);

  cfg_t                  cfg;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [COORD_W-1:0]    rd_val;
  logic signed [COORD_W-1:0] wr_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_val  = pwdata[COORD_W-1:0];

  // Register writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quat_w   <= QUAT_ONE;
      cfg.quat_x   <= '0;
      cfg.quat_y   <= '0;
      cfg.quat_z   <= '0;
      cfg.origin_x <= '0;
      cfg.origin_y <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_QUAT_W:   cfg.quat_w   <= wr_val;
        REG_QUAT_X:   cfg.quat_x   <= wr_val;
        REG_QUAT_Y:   cfg.quat_y   <= wr_val;
        REG_QUAT_Z:   cfg.quat_z   <= wr_val;
        REG_ORIGIN_X: cfg.origin_x <= wr_val;
        REG_ORIGIN_Y: cfg.origin_y <= wr_val;
        default: ;
      endcase
    end
  end

  // Read mux, sign-extended to the bus
  always_comb begin
    unique case (reg_idx)
      REG_QUAT_W:   rd_val = cfg.quat_w;
      REG_QUAT_X:   rd_val = cfg.quat_x;
      REG_QUAT_Y:   rd_val = cfg.quat_y;
      REG_QUAT_Z:   rd_val = cfg.quat_z;
      REG_ORIGIN_X: rd_val = cfg.origin_x;
      REG_ORIGIN_Y: rd_val = cfg.origin_y;
      default:      rd_val = '0;
    endcase
  end
  assign prdata = {{(APB_DATA_W-COORD_W){rd_val[COORD_W-1]}}, rd_val};

  // Datapath
  qpp_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .points (points),
    .pixels (pixels)
  );

endmodule

FILE: tb/quaternion_point_projector_test.sv
// ----------------------------------------------------------------------------
// quaternion_point_projector_test
// Streams model points through the projector under a series of quaternion
// and origin settings, predicts each pixel word in integer math and checks
// every word in order, with random gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module quaternion_point_projector_test;
  import qpp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 240;
  localparam int LAST_PHASE  = 7;
  localparam int PRINT_CAP   = 40;
  // Addresses past the register map; writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct {
    logic        [KIND_W-1:0]  kind;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
  } pixel_t;

  // Holds the register copy and the pixel words still owed by the block
  class pixel_scoreboard;
    cfg_t   cfg;
    pixel_t pending_pixels[$];
    int     mismatches;

    function new();
      cfg.quat_w   = QUAT_ONE;
      cfg.quat_x   = '0;
      cfg.quat_y   = '0;
      cfg.quat_z   = '0;
      cfg.origin_x = '0;
      cfg.origin_y = '0;
      mismatches   = 0;
    endfunction

    task report(string what, longint got, longint want);
      if (mismatches < PRINT_CAP)
        $display("mismatch: %s got %0d want %0d", what, got, want);
      mismatches++;
    endtask

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
      case (idx)
        REG_QUAT_W:   cfg.quat_w   = value;
        REG_QUAT_X:   cfg.quat_x   = value;
        REG_QUAT_Y:   cfg.quat_y   = value;
        REG_QUAT_Z:   cfg.quat_z   = value;
        REG_ORIGIN_X: cfg.origin_x = value;
        REG_ORIGIN_Y: cfg.origin_y = value;
        default: ;
      endcase
    endfunction

    function logic signed [COORD_W-1:0] clamp16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[COORD_W-1:0];
    endfunction

    // Classify, rotate by q*(0,v)*conj(q), truncate, offset and clamp
    function pixel_t project_point(point_t p);
      pixel_t res;
      longint vx, vy, vz, qw, qx, qy, qz;
      longint tw, tx, ty, tz, rx, rz, scale;
      vx = longint'(p.x);
      vy = longint'(p.y);
      vz = longint'(p.z);
      qw = longint'(cfg.quat_w);
      qx = longint'(cfg.quat_x);
      qy = longint'(cfg.quat_y);
      qz = longint'(cfg.quat_z);
      scale = longint'(1) << ROT_SHIFT;
      res.px = '0;
      res.py = '0;
      if (p.x == END_MARK && p.y == END_MARK && p.z == END_MARK) begin
        res.kind = KIND_END;
      end else if (vx < 0 || vy < 0 || vz < 0) begin
        res.kind = KIND_SKIP;
      end else begin
        tw = -qx * vx - qy * vy - qz * vz;
        tx =  qw * vx + qy * vz - qz * vy;
        ty =  qw * vy - qx * vz + qz * vx;
        tz =  qw * vz + qx * vy - qy * vx;
        // conj(q) = (w, -x, -y, -z)
        rx = -tw * qx + tx * qw - ty * qz + tz * qy;
        rz = -tw * qz - tx * qy + ty * qx + tz * qw;
        res.kind = KIND_DRAW;
        res.px = clamp16(rz / scale + longint'(cfg.origin_x) + longint'(PIXEL_BIAS));
        res.py = clamp16(rx / scale + longint'(cfg.origin_y) + longint'(PIXEL_BIAS));
      end
      return res;
    endfunction

    function void note_point(point_t p);
      pending_pixels.push_back(project_point(p));
    endfunction

    task check_pixel(logic [KIND_W-1:0] kind, logic signed [COORD_W-1:0] px,
                     logic signed [COORD_W-1:0] py);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report("pixel word with no point pending, kind", longint'(kind), longint'(0));
      end else begin
        want = pending_pixels.pop_front();
        if (kind !== want.kind) report("point_kind", longint'(kind), longint'(want.kind));
        if (px !== want.px) report("pixel_x", longint'(px), longint'(want.px));
        if (py !== want.py) report("pixel_y", longint'(py), longint'(want.py));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  bit                    calm;

  pixel_scoreboard sb = new();

  qpp_point_if points_ch();
  qpp_pixel_if pixels_ch();

  quaternion_point_projector uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .points  (points_ch),
    .pixels  (pixels_ch)
  );

  always #5 clk = ~clk;

  // Register write: setup cycle, then access cycle until pready;
  // the bus stays selected so the next transfer can follow directly
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
  endtask

  // Register read; the low half must match the value written
  task automatic read_reg(logic [REG_IDX_W-1:0] idx, logic [COORD_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[COORD_W-1:0] !== want)
      sb.report("register readback", longint'(prdata), longint'(want));
  endtask

  // Settings per phase: saturation, non-unit and out-of-range quaternions
  task automatic apply_setting(int phase);
    logic [COORD_W-1:0] qv[4];
    logic [COORD_W-1:0] ox, oy;
    case (phase)
      1: begin
        qv = '{16'h4000, 16'h0000, 16'h0000, 16'h0000};
        ox = 16'h7FFF;
        oy = 16'h7FFF;
      end
      2: begin
        qv = '{16'h4000, 16'h0000, 16'h0000, 16'h0000};
        ox = 16'h8000;
        oy = 16'h8000;
      end
      3: begin
        qv = '{16'h4000, 16'h4000, 16'h4000, 16'h4000};
        ox = 16'h0000;
        oy = 16'h0000;
      end
      4: begin
        qv = '{16'hC000, 16'hC000, 16'hC000, 16'hC000};
        ox = COORD_W'($urandom_range(0, 640));
        oy = COORD_W'($urandom_range(0, 480));
      end
      5: begin
        qv = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
        ox = COORD_W'($urandom);
        oy = COORD_W'($urandom);
      end
      6: begin
        foreach (qv[i]) qv[i] = COORD_W'($urandom_range(0, 32768) - 16384);
        ox = COORD_W'($urandom_range(0, 640));
        oy = COORD_W'($urandom_range(0, 480));
      end
      default: begin
        foreach (qv[i]) qv[i] = COORD_W'($urandom);
        ox = COORD_W'($urandom);
        oy = COORD_W'($urandom);
      end
    endcase
    write_reg(REG_QUAT_W, qv[0]);
    write_reg(REG_QUAT_X, qv[1]);
    write_reg(REG_QUAT_Y, qv[2]);
    write_reg(REG_QUAT_Z, qv[3]);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_SPARE_LO, COORD_W'($urandom));
    write_reg(REG_SPARE_HI, COORD_W'($urandom));
    read_reg(REG_QUAT_W, sb.cfg.quat_w);
    read_reg(REG_QUAT_X, sb.cfg.quat_x);
    read_reg(REG_QUAT_Y, sb.cfg.quat_y);
    read_reg(REG_QUAT_Z, sb.cfg.quat_z);
    read_reg(REG_ORIGIN_X, sb.cfg.origin_x);
    read_reg(REG_ORIGIN_Y, sb.cfg.origin_y);
    // Release the bus
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Non-negative coordinate, biased toward small and extreme values
  function automatic logic signed [COORD_W-1:0] draw_coord();
    case ($urandom_range(0, 3))
      0: return COORD_W'($urandom_range(0, 255));
      1: return COORD_W'($urandom_range(0, 32767));
      2: return END_MARK;
      default: return '0;
    endcase
  endfunction

  // Mostly drawable points; some end markers, noise and near misses
  function automatic point_t random_point();
    point_t p;
    logic signed [COORD_W-1:0] odd;
    int pick;
    pick = $urandom_range(0, 99);
    p.x = draw_coord();
    p.y = draw_coord();
    p.z = draw_coord();
    if (pick < 5) begin
      p = '{END_MARK, END_MARK, END_MARK};
    end else if (pick < 60) begin
      // drawn point as picked
    end else if (pick < 85) begin
      p.x = COORD_W'($urandom);
      p.y = COORD_W'($urandom);
      p.z = COORD_W'($urandom);
    end else begin
      // one coordinate of a drawable point or end marker is set negative or just below END_MARK
      if ($urandom_range(0, 1)) p = '{END_MARK, END_MARK, END_MARK};
      case ($urandom_range(0, 3))
        0: odd = -16'sd1;
        1: odd = 16'sh8000;
        2: odd = END_MARK - 16'sd1;
        default: odd = -$signed(16'($urandom_range(1, 32767)));
      endcase
      case ($urandom_range(0, 2))
        0: p.x = odd;
        1: p.y = odd;
        default: p.z = odd;
      endcase
    end
    return p;
  endfunction

  // Present one point, with an occasional gap first
  task automatic send_point(point_t p);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      points_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points_ch.valid   <= 1'b1;
    points_ch.point_x <= p.x;
    points_ch.point_y <= p.y;
    points_ch.point_z <= p.z;
    do @(posedge clk); while (!points_ch.ready);
    sb.note_point(p);
  endtask

  // Stop the stream and let the pipeline empty before touching registers
  task automatic drain_pipeline();
    points_ch.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Pixel side: check each word, stall in random bursts
  initial begin
    int hold;
    hold = 0;
    pixels_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pixels_ch.valid && pixels_ch.ready)
        sb.check_pixel(pixels_ch.point_kind, pixels_ch.pixel_x, pixels_ch.pixel_y);
      if (hold > 0) begin
        hold--;
        pixels_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 6);
        pixels_ch.ready <= 1'b0;
      end else begin
        pixels_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((points_ch.valid && points_ch.ready) || (pixels_ch.valid && pixels_ch.ready)
          || (psel && penable && pready))
        stalled = 0;
      else
        stalled++;
    end
    $display("status: fail");
    $finish;
  end

  // Main sequence: reset, directed points, then one random phase per setting
  initial begin
    point_t directed_pts [14];
    directed_pts = '{
      '{16'sd0, 16'sd0, 16'sd0},
      '{16'sd32767, 16'sd32767, 16'sd32767},
      '{16'sd32767, 16'sd32767, 16'sd32766},
      '{16'sd32767, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd32767, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd32767},
      '{16'sd1, 16'sd2, 16'sd3},
      '{16'sd100, 16'sd200, 16'sd300},
      '{16'sh8000, 16'sd0, 16'sd0},
      '{16'sd0, -16'sd1, 16'sd0},
      '{16'sd0, 16'sd0, 16'sh8000},
      '{16'sd32767, 16'sd32767, -16'sd1},
      '{-16'sd1, -16'sd1, -16'sd1},
      '{16'sh8000, 16'sh8000, 16'sh8000}
    };
    calm              = 1'b0;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    points_ch.valid   = 1'b0;
    points_ch.point_x = '0;
    points_ch.point_y = '0;
    points_ch.point_z = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: identity quaternion, zero origin
    foreach (directed_pts[i]) send_point(directed_pts[i]);
    for (int phase = 1; phase <= LAST_PHASE; phase++) begin
      drain_pipeline();
      apply_setting(phase);
      calm = (phase == LAST_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) send_point(random_point());
    end
    drain_pipeline();

    if (sb.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: sim.f
sv/qpp_pkg.sv
sv/qpp_ifs.sv
sv/qpp_pipe.sv
sv/quaternion_point_projector.sv
tb/quaternion_point_projector_test.sv
